### src/ppmfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppmfd_pkg: shared types and constants of the PPM frame decoder
// Register map, reset values of the timing bounds and the scaling constants.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SYNC_MIN  = 2'd0,
    REG_SYNC_MAX  = 2'd1,
    REG_PULSE_MIN = 2'd2,
    REG_PULSE_MAX = 2'd3
  } reg_idx_e;

  // reset values of the timing bounds, half-microsecond ticks
  localparam logic [15:0] SYNC_MIN_RST  = 16'd6000;
  localparam logic [15:0] SYNC_MAX_RST  = 16'd60000;
  localparam logic [15:0] PULSE_MIN_RST = 16'd1400;
  localparam logic [15:0] PULSE_MAX_RST = 16'd4600;

  // scaling (stored - 3000) * 2048 / 1000
  localparam logic signed [17:0] SCALE_OFFSET = 18'sd3000;
  // offsets at or above this scale past the top of the 14-bit range
  localparam logic signed [17:0] SAT_DIFF     = 18'sd4000;
  // floor(n * 256 / 125) == (n * RECIP_M) >> RECIP_SHIFT for n below 4096
  localparam logic [20:0]        RECIP_M      = 21'd1073742;
  localparam int                 RECIP_SHIFT  = 19;
  localparam logic signed [13:0] VAL_MAX      = 14'sd8191;

  typedef logic [15:0] bound_t;

endpackage : ppmfd_pkg
`default_nettype wire

### src/ppm_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_frame_decoder: RC pulse-position stream decoder
// Tracks frame sync from captured interval lengths, stores channel pulses
// and returns a stored channel scaled to a signed 14-bit value on request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | cmd_i, pulse_len_i, channel_i
//  out     | output    | out_valid_o/out_ready_i | value_o, synced_o
//  cfg     | input     | APB psel/penable/pready | paddr, pwdata, prdata
//
//  Each request gives exactly one result, held in the input register, then
//  in the result register. One request per cycle sustained while results
//  are taken; the scale multiplier sits between the two registers and sets
//  the cycle time.
//  A stalled result stops the input register only once it is also full.
//  Reset clears sync, sets the slot index to 0 and marks every channel as -1.
// ----------------------------------------------------------------------------
module ppm_frame_decoder
  import ppmfd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic [15:0]        pulse_len_i,
  input  wire logic [2:0]         channel_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [13:0]      value_o,
  output logic                    synced_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // slot index held with an offset of one: 0 means slot -1
  localparam int SW = $clog2(CHANNELS + 2);
  localparam logic [SW-1:0] SLOT_TOP = SW'(CHANNELS + 1);

  // configuration registers
  bound_t sync_min_q, sync_max_q, pulse_min_q, pulse_max_q;
  reg_idx_e cfg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_min_q  <= SYNC_MIN_RST;
      sync_max_q  <= SYNC_MAX_RST;
      pulse_min_q <= PULSE_MIN_RST;
      pulse_max_q <= PULSE_MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SYNC_MIN:  sync_min_q  <= pwdata[15:0];
        REG_SYNC_MAX:  sync_max_q  <= pwdata[15:0];
        REG_PULSE_MIN: pulse_min_q <= pwdata[15:0];
        REG_PULSE_MAX: pulse_max_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_SYNC_MIN:  prdata = {16'd0, sync_min_q};
      REG_SYNC_MAX:  prdata = {16'd0, sync_max_q};
      REG_PULSE_MIN: prdata = {16'd0, pulse_min_q};
      REG_PULSE_MAX: prdata = {16'd0, pulse_max_q};
      default:       prdata = 32'd0;
    endcase
  end

  // input register and flow control
  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [15:0] s1_len_q;
  logic [2:0]  s1_ch_q;
  logic        s1_adv;

  assign s1_adv     = s1_valid_q & (~out_valid_o | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q <= cmd_i;
      s1_len_q <= pulse_len_i;
      s1_ch_q  <= channel_i;
    end
  end

  // decoder state
  logic              sync_q, sync_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [CHANNELS-1:0] ch_vld_q;
  logic [15:0]       ch_data_q [CHANNELS];

  // sync tracking and slot advance for a pulse request
  logic          sync_hit, pulse_ok, store_en;
  logic [SW-1:0] wr_pos;

  assign sync_hit = (s1_len_q > sync_min_q) && (s1_len_q < sync_max_q);
  assign pulse_ok = (s1_len_q < pulse_max_q) && (s1_len_q > pulse_min_q);

  always_comb begin
    sync_d   = sync_q;
    slot_d   = slot_q;
    store_en = 1'b0;
    if (!s1_cmd_q) begin
      if (sync_hit) begin
        sync_d = 1'b1;
        slot_d = '0;
      end else begin
        if (slot_q < SLOT_TOP) begin
          slot_d = slot_q + SW'(1);
        end
        if (sync_q) begin
          if (pulse_ok) begin
            store_en = (slot_d != '0) && (slot_d != SLOT_TOP);
          end else begin
            sync_d = 1'b0;
          end
        end
      end
    end
  end

  assign wr_pos = slot_d - SW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= 1'b0;
      slot_q   <= SW'(1);
      ch_vld_q <= '0;
    end else if (s1_adv) begin
      sync_q <= sync_d;
      slot_q <= slot_d;
      if (store_en) begin
        ch_vld_q[wr_pos[IW-1:0]] <= 1'b1;
      end
    end
  end

  // channel store data
  always_ff @(posedge clk_i) begin
    if (s1_adv && store_en) begin
      ch_data_q[wr_pos[IW-1:0]] <= s1_len_q;
    end
  end

  // channel read and scaling
  logic                 rd_in_range;
  logic [IW-1:0]        rd_idx;
  logic [IW+2:0]        ch_ext;
  logic signed [17:0]   stored_s, diff_s;
  logic                 diff_neg, diff_sat;
  logic [17:0]          diff_abs;
  logic [32:0]          prod;
  logic [12:0]          quot;
  logic signed [13:0]   scaled, value_d;

  assign ch_ext      = (IW + 3)'(s1_ch_q);
  assign rd_idx      = ch_ext[IW-1:0];
  assign rd_in_range = 32'(s1_ch_q) < CHANNELS;

  always_comb begin
    stored_s = ch_vld_q[rd_idx] ? $signed({2'b00, ch_data_q[rd_idx]}) : -18'sd1;
    diff_s   = stored_s - SCALE_OFFSET;
    diff_neg = diff_s[17];
    diff_sat = diff_s >= SAT_DIFF;
    diff_abs = diff_neg ? 18'(-diff_s) : 18'(diff_s);
    prod     = 33'(diff_abs[11:0]) * 33'(RECIP_M);
    quot     = prod[RECIP_SHIFT+12:RECIP_SHIFT];
    if (diff_sat) begin
      scaled = VAL_MAX;
    end else if (diff_neg) begin
      scaled = -$signed({1'b0, quot});
    end else begin
      scaled = $signed({1'b0, quot});
    end
    value_d = (s1_cmd_q && rd_in_range) ? scaled : 14'sd0;
  end

  // result register
  logic out_read_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      value_o    <= value_d;
      synced_o   <= sync_d;
      out_read_q <= s1_cmd_q;
    end
  end

  // checks
  a_sync_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_cmd_q && sync_hit |=> out_valid_o && synced_o && sync_q)
    else $error("sync interval did not set the sync flag");

  a_pulse_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_read_q |-> value_o == 14'sd0)
    else $error("pulse request returned a nonzero value");

  a_slot_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_TOP)
    else $error("slot index beyond saturation");

  a_store_needs_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && store_en |-> sync_q && !s1_cmd_q && pulse_ok)
    else $error("channel stored without sync");

endmodule : ppm_frame_decoder
`default_nettype wire
